// File: sv/sensor_frame_deframer_assert.svh
// ============================================================================
// Assertion macros for the sensor frame deframer
// Wrap concurrent assertions on clk / rst_n; compile to nothing under SYNTH.
// ============================================================================
`ifndef SENSOR_FRAME_DEFRAMER_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH

// Check cons in the same cycle that ante holds.
`define SFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor_frame_deframer: same-cycle check failed");

// Check cons in the cycle after ante holds.
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor_frame_deframer: next-cycle check failed");

`else

`define SFD_ASSERT_SAME(label, ante, cons)
`define SFD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/sfd_pkg.sv
// ============================================================================
// sfd_pkg
// Types and constants shared by the sensor frame deframer.
// ============================================================================
`default_nettype none

package sfd_pkg;

    // Default largest frame, header and check bytes included
    localparam int unsigned DEF_MAX_FRAME = 512;

    // Start-of-frame marker
    localparam logic [7:0] SOF_VALUE = 8'h01;

    // Header byte positions (start byte is position 0)
    localparam logic [2:0] HDR_POS_FIRST  = 3'd1;
    localparam logic [2:0] HDR_POS_LEN_HI = 3'd3;
    localparam logic [2:0] HDR_POS_LEN_LO = 3'd4;
    localparam logic [2:0] HDR_POS_TYP_HI = 3'd5;
    localparam logic [2:0] HDR_POS_TYP_LO = 3'd6;
    localparam logic [2:0] HDR_POS_CHECK  = 3'd7;

    // Result kinds carried on tuser
    localparam int unsigned KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_BYTE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HDR_FAIL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA_FAIL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD_LEN   = 3'd4;

    // Result field widths
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned TDATA_W = 56;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

endpackage

`default_nettype wire

// File: sv/sensor_frame_deframer.sv
// ============================================================================
// sensor_frame_deframer
// Recover start/length framed sensor records from a byte stream, pass the
// payload bytes on and close each frame attempt with a verdict.
// ============================================================================
//
// Channel   Dir   tdata / tuser / tlast
// --------  ----  -----------------------------------------------------------
// s_*       in    tdata[7:0] rx_byte
// m_*       out   tdata: frame_type, frame_len, payload_byte, byte_index
//                 tuser: result_kind, tlast: last
//
// Each accepted byte lands in an input register and is decoded from there
// straight into the result register: one byte per cycle sustained as long
// as m_tready stays high.
// A byte that gives no result (hunting, header bytes) still passes through
// the input register and, like any byte, waits there while a stalled
// result holds the result register.
// A stalled result holds the input register; s_tready drops only when both
// the input and the result register are occupied and m_tready is low.
// Reset (rst_n low, asynchronous) returns to hunting with both registers
// empty; no clearing pass is needed.
//
`default_nettype none

module sensor_frame_deframer #(
    parameter int unsigned MAX_FRAME = sfd_pkg::DEF_MAX_FRAME
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] rx_byte

    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [15:0] frame_type, [31:16] frame_len, [39:32] payload_byte,
    // [48:40] byte_index, [55:49] zero
    output logic [sfd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [sfd_pkg::KIND_W-1:0]        m_tuser,   // [2:0] result_kind
    output logic                              m_tlast
);

    // Payload counter only needs to reach the largest legal length
    localparam int unsigned CNT_W = $clog2(MAX_FRAME - 8);
    // Longest payload accepted; wider than 16 bits so the compare is exact
    localparam logic [16:0] LEN_LIMIT = 17'(MAX_FRAME - 9);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    sfd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       pos_reg,   pos_next;
    logic [7:0]       hxor_reg,  hxor_next;
    logic [15:0]      len_reg,   len_next;
    logic [15:0]      type_reg,  type_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [7:0]       pxor_reg,  pxor_next;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                         out_valid_reg;
    logic [sfd_pkg::KIND_W-1:0]   out_kind_reg;
    logic [15:0]                  out_type_reg;
    logic [15:0]                  out_len_reg;
    logic [7:0]                   out_byte_reg;
    logic [sfd_pkg::IDX_W-1:0]    out_idx_reg;
    logic                         out_last_reg;

    logic                         res_valid;
    logic [sfd_pkg::KIND_W-1:0]   res_kind;
    logic [7:0]                   res_byte;
    logic [sfd_pkg::IDX_W-1:0]    res_idx;
    logic                         res_last;

    logic [CNT_W-1:0] cnt_inc;
    logic [31:0]      cnt_wide;
    logic             len_too_long;
    logic             payload_done;

    // Decode the held byte whenever the result register can take a result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cnt_inc      = cnt_reg + 1'b1;
    assign cnt_wide     = 32'(cnt_reg);
    assign len_too_long = {1'b0, len_reg} > LEN_LIMIT;
    assign payload_done = 17'(cnt_inc) >= {1'b0, len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Per-byte frame decoding
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hxor_next  = hxor_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        cnt_next   = cnt_reg;
        pxor_next  = pxor_reg;
        res_valid  = 1'b0;
        res_kind   = sfd_pkg::KIND_BYTE;
        res_byte   = 8'd0;
        res_idx    = '0;
        res_last   = 1'b0;

        if (advance)
        begin
            case (phase_reg)
                sfd_pkg::PH_HUNT:
                begin
                    // Drop everything until a start byte shows up
                    if (in_byte_reg == sfd_pkg::SOF_VALUE)
                    begin
                        pos_next   = sfd_pkg::HDR_POS_FIRST;
                        hxor_next  = in_byte_reg;
                        phase_next = sfd_pkg::PH_HEADER;
                    end
                end

                sfd_pkg::PH_HEADER:
                begin
                    if (pos_reg != sfd_pkg::HDR_POS_CHECK)
                    begin
                        case (pos_reg)
                            sfd_pkg::HDR_POS_LEN_HI: len_next  = {in_byte_reg, len_reg[7:0]};
                            sfd_pkg::HDR_POS_LEN_LO: len_next  = {len_reg[15:8], in_byte_reg};
                            sfd_pkg::HDR_POS_TYP_HI: type_next = {in_byte_reg, type_reg[7:0]};
                            sfd_pkg::HDR_POS_TYP_LO: type_next = {type_reg[15:8], in_byte_reg};
                            default: ;
                        endcase
                        hxor_next = hxor_reg ^ in_byte_reg;
                        pos_next  = pos_reg + 3'd1;
                    end
                    else
                    begin
                        // Header check byte: length test wins over check test
                        pos_next = 3'd0;
                        if (len_too_long)
                        begin
                            phase_next = sfd_pkg::PH_HUNT;
                            res_valid  = 1'b1;
                            res_kind   = sfd_pkg::KIND_BAD_LEN;
                            res_last   = 1'b1;
                        end
                        else if (~hxor_reg != in_byte_reg)
                        begin
                            phase_next = sfd_pkg::PH_HUNT;
                            res_valid  = 1'b1;
                            res_kind   = sfd_pkg::KIND_HDR_FAIL;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            pxor_next  = 8'd0;
                            phase_next = (len_reg == 16'd0) ? sfd_pkg::PH_CHECK
                                                            : sfd_pkg::PH_PAYLOAD;
                        end
                    end
                end

                sfd_pkg::PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    res_kind  = sfd_pkg::KIND_BYTE;
                    res_byte  = in_byte_reg;
                    res_idx   = cnt_wide[sfd_pkg::IDX_W-1:0];
                    pxor_next = pxor_reg ^ in_byte_reg;
                    cnt_next  = cnt_inc;
                    if (payload_done)
                    begin
                        phase_next = sfd_pkg::PH_CHECK;
                    end
                end

                default:
                begin
                    // Data check byte closes the frame
                    phase_next = sfd_pkg::PH_HUNT;
                    res_valid  = 1'b1;
                    res_kind   = (~pxor_reg == in_byte_reg) ? sfd_pkg::KIND_GOOD
                                                            : sfd_pkg::KIND_DATA_FAIL;
                    res_last   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfd_pkg::PH_HUNT;
            pos_reg   <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hxor_reg <= hxor_next;
        len_reg  <= len_next;
        type_reg <= type_next;
        cnt_reg  <= cnt_next;
        pxor_reg <= pxor_next;
    end

    // Load a fresh result, or drop the current one once it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_kind_reg <= res_kind;
            out_type_reg <= type_next;
            out_len_reg  <= len_next;
            out_byte_reg <= res_byte;
            out_idx_reg  <= res_idx;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_idx_reg, out_byte_reg, out_len_reg, out_type_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "sensor_frame_deframer_assert.svh"

    `SFD_ASSERT_SAME(a_hunt_pos_clear, phase_reg == sfd_pkg::PH_HUNT, pos_reg == 3'd0)
    `SFD_ASSERT_SAME(a_payload_in_range, phase_reg == sfd_pkg::PH_PAYLOAD,
                     17'(cnt_reg) < {1'b0, len_reg})
    `SFD_ASSERT_SAME(a_byte_not_last, m_tvalid && m_tuser == sfd_pkg::KIND_BYTE, !m_tlast)
    `SFD_ASSERT_NEXT(a_payload_gives_result, advance && phase_reg == sfd_pkg::PH_PAYLOAD,
                     m_tvalid)

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ============================================================================
// Sensor frame deframer testbench
// Drives byte streams into the deframer: noise, clean frames, frames with a
// bad header check, an implausible length or a bad data check. A local
// decoder predicts each result, and every output transfer is compared with
// the oldest prediction. Both stream sides idle at random.
// ============================================================================

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Longest payload the deframer takes before rejecting the length.
    localparam int unsigned MAX_PAYLOAD = sfd_pkg::DEF_MAX_FRAME - 9;
    // Cycles with no transfer on either side before the run is abandoned.
    localparam int unsigned IDLE_LIMIT = 2000;
    // Cycles to let pass once nothing is pending: covers the two-stage pipe.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Input bytes to send over the whole run; the random stream fills up.
    localparam int unsigned TOTAL_ITEMS = 630;

    typedef struct packed {
        logic [sfd_pkg::KIND_W-1:0] kind;
        logic [15:0]                ftype;
        logic [15:0]                flen;
        logic [7:0]                 pbyte;
        logic [sfd_pkg::IDX_W-1:0]  idx;
        logic                       last;
    } frame_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata = 8'h00;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [sfd_pkg::TDATA_W-1:0] m_tdata;
    logic [sfd_pkg::KIND_W-1:0]  m_tuser;
    logic                        m_tlast;

    sensor_frame_deframer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] type, [31:16] len, [39:32] byte, [48:40] index
        .m_tuser  (m_tuser),   // [2:0] result_kind
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder state, kept apart from the design
    // ------------------------------------------------------------------
    sfd_pkg::phase_t dec_phase = sfd_pkg::PH_HUNT;
    logic [2:0]      dec_hdr_pos = '0;
    logic [7:0]      dec_hdr_xor = '0;
    logic [15:0]     dec_len = '0;
    logic [15:0]     dec_type = '0;
    logic [15:0]     dec_count = '0;
    logic [7:0]      dec_pay_xor = '0;

    frame_result_t pending_results[$];
    int unsigned   error_count = 0;
    int unsigned   sent_bytes = 0;

    // Sender burst bookkeeping
    bit            tx_on = 1'b0;
    int unsigned   burst_left = 1;

    task automatic report(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic push_result(input logic [sfd_pkg::KIND_W-1:0] kind,
                               input logic [7:0] pbyte,
                               input logic [sfd_pkg::IDX_W-1:0] idx, input logic last);
        frame_result_t r;
        r.kind  = kind;
        r.ftype = dec_type;
        r.flen  = dec_len;
        r.pbyte = pbyte;
        r.idx   = idx;
        r.last  = last;
        pending_results.push_back(r);
    endtask

    // Advance the decoder by one accepted byte and queue what it yields.
    task automatic decode_byte(input logic [7:0] b);
        case (dec_phase)
            sfd_pkg::PH_HUNT:
            begin
                if (b == sfd_pkg::SOF_VALUE)
                begin
                    dec_hdr_pos = sfd_pkg::HDR_POS_FIRST;
                    dec_hdr_xor = b;
                    dec_phase   = sfd_pkg::PH_HEADER;
                end
            end
            sfd_pkg::PH_HEADER:
            begin
                if (dec_hdr_pos != sfd_pkg::HDR_POS_CHECK)
                begin
                    case (dec_hdr_pos)
                        sfd_pkg::HDR_POS_LEN_HI: dec_len[15:8]  = b;
                        sfd_pkg::HDR_POS_LEN_LO: dec_len[7:0]   = b;
                        sfd_pkg::HDR_POS_TYP_HI: dec_type[15:8] = b;
                        sfd_pkg::HDR_POS_TYP_LO: dec_type[7:0]  = b;
                        default: ;
                    endcase
                    dec_hdr_xor = dec_hdr_xor ^ b;
                    dec_hdr_pos = dec_hdr_pos + 3'd1;
                end
                else
                begin
                    // Length test outranks the header check.
                    dec_hdr_pos = '0;
                    if (32'(dec_len) > MAX_PAYLOAD)
                    begin
                        dec_phase = sfd_pkg::PH_HUNT;
                        push_result(sfd_pkg::KIND_BAD_LEN, 8'h00, '0, 1'b1);
                    end
                    else if (~dec_hdr_xor != b)
                    begin
                        dec_phase = sfd_pkg::PH_HUNT;
                        push_result(sfd_pkg::KIND_HDR_FAIL, 8'h00, '0, 1'b1);
                    end
                    else
                    begin
                        dec_count   = '0;
                        dec_pay_xor = '0;
                        dec_phase   = (dec_len == 16'd0) ? sfd_pkg::PH_CHECK
                                                         : sfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            sfd_pkg::PH_PAYLOAD:
            begin
                push_result(sfd_pkg::KIND_BYTE, b, dec_count[sfd_pkg::IDX_W-1:0], 1'b0);
                dec_pay_xor = dec_pay_xor ^ b;
                dec_count   = dec_count + 16'd1;
                if (dec_count >= dec_len)
                    dec_phase = sfd_pkg::PH_CHECK;
            end
            default:
            begin
                dec_phase = sfd_pkg::PH_HUNT;
                push_result((~dec_pay_xor == b) ? sfd_pkg::KIND_GOOD
                                                : sfd_pkg::KIND_DATA_FAIL,
                            8'h00, '0, 1'b1);
            end
        endcase
    endtask

    // Offer one byte, hold it until the transfer, then maybe end the burst.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        s_tdata <= b;
        if (!tx_on)
        begin
            s_tvalid <= 1'b1;
            tx_on = 1'b1;
        end
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b);
        sent_bytes++;
        burst_left--;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            tx_on = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                      : $urandom_range(1, 24);
        end
    endtask

    // Send one frame attempt; stop after the header if it is to be rejected.
    task automatic send_frame(input int unsigned plen, input logic [15:0] ftype,
                              input bit bad_hdr, input bit bad_data, input bit extremes);
        logic [7:0] hdr [0:7];
        logic [7:0] acc;
        logic [7:0] b;
        int unsigned i;
        hdr[0] = sfd_pkg::SOF_VALUE;
        hdr[1] = 8'($urandom);
        hdr[2] = 8'($urandom);
        hdr[3] = plen[15:8];
        hdr[4] = plen[7:0];
        hdr[5] = ftype[15:8];
        hdr[6] = ftype[7:0];
        acc = '0;
        for (i = 0; i < 7; i++)
            acc = acc ^ hdr[i];
        hdr[7] = ~acc;
        if (bad_hdr)
            hdr[7] = hdr[7] ^ 8'($urandom_range(1, 255));
        for (i = 0; i < 8; i++)
            send_byte(hdr[i]);
        if (bad_hdr || plen > MAX_PAYLOAD)
            return;
        acc = '0;
        for (i = 0; i < plen; i++)
        begin
            b = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
            acc = acc ^ b;
            send_byte(b);
        end
        b = ~acc;
        if (bad_data)
            b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
    endtask

    // Release the input and wait until every predicted result has arrived.
    task automatic drain;
        if (tx_on)
        begin
            s_tvalid <= 1'b0;
            tx_on = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_hunt_noise;
        // Drop everything but the start byte: none of these yields a result.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h80);
        drain();
    endtask

    task automatic test_empty_frame;
        // Zero length goes straight to the data check, which must be 0xFF.
        send_frame(0, 16'h0000, 1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_bad_length;
        // Just above the limit with a broken header check: length wins.
        send_frame(MAX_PAYLOAD + 1, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'h5AA5, 1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_header_check;
        send_frame(3, 16'hA55A, 1'b1, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_payload_frames;
        send_frame(2, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_frame(1, 16'h0001, 1'b0, 1'b1, 1'b0);
        drain();
    endtask

    task automatic test_longest_frame;
        // Carry the byte index up to the largest value a legal frame gives it.
        send_frame(MAX_PAYLOAD, 16'($urandom), 1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_random_stream;
        int unsigned pick;
        int unsigned plen;
        int unsigned n;
        int unsigned i;
        logic [15:0] ftype;
        while (sent_bytes < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 8)
                 : ($urandom_range(0, 3) != 0) ? $urandom_range(9, 24)
                 : $urandom_range(25, 48);
            case ($urandom_range(0, 7))
                0:       ftype = 16'h0000;
                1:       ftype = 16'hFFFF;
                default: ftype = 16'($urandom);
            endcase
            if (pick < 10)
            begin
                // Noise, or a start byte with a torn header behind it.
                n = $urandom_range(1, 10);
                if ($urandom_range(0, 1) != 0)
                    send_byte(sfd_pkg::SOF_VALUE);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom));
            end
            else if (pick < 20)
                send_frame(plen, ftype, 1'b1, 1'b0, 1'b0);
            else if (pick < 30)
            begin
                case ($urandom_range(0, 3))
                    0:       plen = MAX_PAYLOAD + 1;
                    1:       plen = 16'hFFFF;
                    default: plen = $urandom_range(MAX_PAYLOAD + 1, 16'hFFFF);
                endcase
                send_frame(plen, ftype, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end
            else if (pick < 45)
                send_frame(plen, ftype, 1'b0, 1'b1, 1'b0);
            else
                send_frame(plen, ftype, 1'b0, 1'b0, 1'b0);
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver: switch at random between patterns of ready and stalled cycles
    // ------------------------------------------------------------------
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(16, 96);
        end
        else
            rx_mode_left <= rx_mode_left - 1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_mode_left[4:0] >= 5'd24);
        endcase
    end

    // ------------------------------------------------------------------
    // Compare each output transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report($sformatf("result kind %0d with nothing pending", m_tuser));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[15:0] !== want.ftype)
                    report($sformatf("type %h, want %h", m_tdata[15:0], want.ftype));
                if (m_tdata[31:16] !== want.flen)
                    report($sformatf("len %h, want %h", m_tdata[31:16], want.flen));
                if (m_tdata[39:32] !== want.pbyte)
                    report($sformatf("byte %h, want %h", m_tdata[39:32], want.pbyte));
                if (m_tdata[48:40] !== want.idx)
                    report($sformatf("index %0d, want %0d", m_tdata[48:40], want.idx));
                if (m_tdata[55:49] !== '0)
                    report($sformatf("pad bits %h not zero", m_tdata[55:49]));
                if (m_tlast !== want.last)
                    report($sformatf("last %b, want %b", m_tlast, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abandon the run after too long without any transfer
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_hunt_noise();
        test_empty_frame();
        test_bad_length();
        test_header_check();
        test_payload_frames();
        test_longest_frame();
        test_random_stream();
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
